FILE: hdl/rc4_pkg.sv
// ============================================================================
// rc4_pkg: shared types and constants for the RC4 keystream engine
// Item modes, permutation table access codes, and the command and status
// bundles that join the controller to the datapath.
// ============================================================================
package rc4_pkg;

    // item modes
    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_CRYPT = 2'd1;
    localparam logic [1:0] MODE_SKIP  = 2'd2;
    localparam logic [1:0] MODE_BACK  = 2'd3;

    // last index of the permutation table
    localparam logic [7:0] IDX_MAX = 8'd255;

    // table read address select
    localparam logic [2:0] RD_NONE = 3'd0;
    localparam logic [2:0] RD_I1   = 3'd1;  // i + 1
    localparam logic [2:0] RD_I    = 3'd2;  // i
    localparam logic [2:0] RD_JA   = 3'd3;  // j + S[i] (+ key byte)
    localparam logic [2:0] RD_J    = 3'd4;  // j
    localparam logic [2:0] RD_T    = 3'd5;  // S[i] + S[j]

    // table write select
    localparam logic [1:0] WR_NONE    = 2'd0;
    localparam logic [1:0] WR_I_RDATA = 2'd1;  // S[i] <= read data
    localparam logic [1:0] WR_J_A     = 2'd2;  // S[j] <= held a
    localparam logic [1:0] WR_I_B     = 2'd3;  // S[i] <= held b

    typedef struct packed {
        logic [2:0] rd_sel;
        logic [1:0] wr_sel;
        logic       i_inc;
        logic       i_dec;
        logic       j_add;
        logic       j_sub;
        logic       use_key;
        logic       cap_a;
        logic       cap_b;
        logic       key_wr;
        logic       key_rd;
        logic       key_step;
        logic       sched_init;
        logic       sched_done;
        logic       latch_data;
        logic       cap_res;
        logic       out_load;
        logic       out_from_res;
    } t_dp_cmd;

    typedef struct packed {
        logic i_max;
    } t_dp_status;

endpackage

FILE: hdl/rc4_stream_cipher.sv
// ============================================================================
// rc4_stream_cipher: RC4 keystream engine, top level
// Sequencer plus datapath around a 256-entry permutation table.
// ============================================================================
// One item is taken at a time. A key byte is written to the key buffer;
// the byte marked last adds the key schedule, 256 rounds that each read
// S[i] and S[j] and write the swap back. A crypt byte makes two table
// reads, the swap written as two writes and the output read, all through
// the table's one read and one write port; its result beat waits in an
// output register, and while that register is still full the next result
// holds the sequencer. Skip and back items run one generator step per
// count, none at a count of zero. The table resets to identity at once
// through per-entry valid bits, so there is no clearing pass after reset.
module rc4_stream_cipher #(
    parameter int KEY_DEPTH   = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_mode,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_key_last,
    input  logic [COUNT_WIDTH-1:0] i_step_count,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [7:0]             o_out_byte
);

    rc4_pkg::t_dp_cmd    dp_cmd;
    rc4_pkg::t_dp_status dp_status;

    // sequencer
    rc4_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_mode       (i_mode),
        .i_key_last   (i_key_last),
        .i_step_count (i_step_count),
        .i_stall      (i_stall),
        .i_status     (dp_status),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .o_cmd        (dp_cmd)
    );

    // table, key buffer and result path
    rc4_dpath #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_data_byte (i_data_byte),
        .o_status    (dp_status),
        .o_out_byte  (o_out_byte)
    );

endmodule

FILE: hdl/rc4_dpath.sv
// ============================================================================
// rc4_dpath: RC4 datapath
// Permutation table with valid bits, key buffer, indices, swap holding
// registers, keystream bypass and the result register.
// ============================================================================
module rc4_dpath #(
    parameter int KEY_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rc4_pkg::t_dp_cmd     i_cmd,
    input  logic [7:0]           i_data_byte,
    output rc4_pkg::t_dp_status  o_status,
    output logic [7:0]           o_out_byte
);

    localparam int KW   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KCW  = $clog2(KEY_DEPTH + 1);
    localparam int KCW1 = KCW + 1;

    // permutation table and its valid bits
    logic [7:0]   mem [0:255];
    logic [255:0] r_vld;
    logic [7:0]   r_rd_data;
    logic         r_rd_vld;
    logic [7:0]   r_rd_addr;

    // key buffer
    logic [7:0]     key_mem [0:KEY_DEPTH-1];
    logic [7:0]     r_key_rd;
    logic [KCW-1:0] r_key_count;
    logic [KW-1:0]  r_kp;

    // indices and holding registers
    logic [7:0] r_i;
    logic [7:0] r_j;
    logic [7:0] r_a;
    logic [7:0] r_b;
    logic       r_hit_i;
    logic       r_hit_j;
    logic [7:0] r_data;
    logic [7:0] r_res;
    logic [7:0] r_out;

    logic [7:0]  rdata;
    logic [7:0]  key_term;
    logic [7:0]  j_sum;
    logic [7:0]  t_sum;
    logic [7:0]  ks;
    logic [7:0]  raddr;
    logic        rd_en;
    logic [7:0]  waddr;
    logic [7:0]  wdata;
    logic        wr_en;
    logic [KCW1-1:0] kp_inc;

    // unwritten entries read as identity
    assign rdata    = r_rd_vld ? r_rd_data : r_rd_addr;
    assign key_term = i_cmd.use_key ? r_key_rd : 8'd0;
    assign j_sum    = r_j + rdata + key_term;
    assign t_sum    = r_a + rdata;

    // forward the swapped values when the output index hits i or j
    assign ks = r_hit_j ? r_a : (r_hit_i ? r_b : rdata);

    // select read address
    always_comb begin
        rd_en = 1'b1;
        case (i_cmd.rd_sel)
            rc4_pkg::RD_I1: raddr = r_i + 8'd1;
            rc4_pkg::RD_I:  raddr = r_i;
            rc4_pkg::RD_JA: raddr = j_sum;
            rc4_pkg::RD_J:  raddr = r_j;
            rc4_pkg::RD_T:  raddr = t_sum;
            default: begin
                raddr = r_i;
                rd_en = 1'b0;
            end
        endcase
    end

    // select write address and data
    always_comb begin
        wr_en = 1'b1;
        unique case (i_cmd.wr_sel)
            rc4_pkg::WR_I_RDATA: begin
                waddr = r_i;
                wdata = rdata;
            end
            rc4_pkg::WR_J_A: begin
                waddr = r_j;
                wdata = r_a;
            end
            rc4_pkg::WR_I_B: begin
                waddr = r_i;
                wdata = r_b;
            end
            default: begin
                waddr = r_i;
                wdata = r_a;
                wr_en = 1'b0;
            end
        endcase
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[raddr];
            r_rd_vld  <= r_vld[raddr];
            r_rd_addr <= raddr;
        end
    end

    // drop all entries back to identity on reset or schedule start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sched_init) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[waddr] <= 1'b1;
        end
    end

    // advance indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sched_init) begin
            r_i <= 8'd0;
            r_j <= 8'd0;
        end else begin
            if (i_cmd.i_inc) begin
                r_i <= r_i + 8'd1;
            end else if (i_cmd.i_dec) begin
                r_i <= r_i - 8'd1;
            end
            if (i_cmd.sched_done) begin
                r_j <= 8'd0;
            end else if (i_cmd.j_add) begin
                r_j <= j_sum;
            end else if (i_cmd.j_sub) begin
                r_j <= r_j - r_b;
            end
        end
    end

    // hold swap operands and bypass flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_a <= rdata;
        end
        if (i_cmd.cap_b) begin
            r_b     <= rdata;
            r_hit_i <= (t_sum == r_i);
            r_hit_j <= (t_sum == r_j);
        end
        if (i_cmd.latch_data) begin
            r_data <= i_data_byte;
        end
        if (i_cmd.cap_res) begin
            r_res <= ks;
        end
        if (i_cmd.out_load) begin
            r_out <= r_data ^ (i_cmd.out_from_res ? r_res : ks);
        end
    end

    // store key bytes, ignore those beyond the buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr && (r_key_count < KCW'(KEY_DEPTH))) begin
            key_mem[r_key_count[KW-1:0]] <= i_data_byte;
        end
        if (i_cmd.key_rd) begin
            r_key_rd <= key_mem[r_kp];
        end
    end

    assign kp_inc = KCW1'(r_kp) + KCW1'(1);

    // key count and repeating key pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sched_done) begin
            r_key_count <= '0;
            r_kp        <= '0;
        end else begin
            if (i_cmd.key_wr && (r_key_count < KCW'(KEY_DEPTH))) begin
                r_key_count <= r_key_count + KCW'(1);
            end
            if (i_cmd.sched_init) begin
                r_kp <= '0;
            end else if (i_cmd.key_step) begin
                if (kp_inc >= KCW1'(r_key_count)) begin
                    r_kp <= '0;
                end else begin
                    r_kp <= kp_inc[KW-1:0];
                end
            end
        end
    end

    assign o_status.i_max = (r_i == rc4_pkg::IDX_MAX);
    assign o_out_byte     = r_out;

endmodule

FILE: hdl/rc4_ctrl.sv
// ============================================================================
// rc4_ctrl: RC4 sequencer
// Takes items, steps the datapath through key schedule, generator steps
// forward and back, and owns the result beat handshake.
// ============================================================================
module rc4_ctrl #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [1:0]             i_mode,
    input  logic                   i_key_last,
    input  logic [COUNT_WIDTH-1:0] i_step_count,
    input  logic                   i_stall,
    input  rc4_pkg::t_dp_status    i_status,
    output logic                   o_stall,
    output logic                   o_valid,
    output rc4_pkg::t_dp_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_F_RD_I   = 4'd1;
    localparam logic [3:0] S_F_RD_J   = 4'd2;
    localparam logic [3:0] S_F_SWAP   = 4'd3;
    localparam logic [3:0] S_F_DONE   = 4'd4;
    localparam logic [3:0] S_K_RD_I   = 4'd5;
    localparam logic [3:0] S_K_RD_J   = 4'd6;
    localparam logic [3:0] S_K_SWAP   = 4'd7;
    localparam logic [3:0] S_K_DONE   = 4'd8;
    localparam logic [3:0] S_B_RD_I   = 4'd9;
    localparam logic [3:0] S_B_RD_J   = 4'd10;
    localparam logic [3:0] S_B_SWAP   = 4'd11;
    localparam logic [3:0] S_B_DONE   = 4'd12;
    localparam logic [3:0] S_OUT_WAIT = 4'd13;

    logic [3:0]             r_state;
    logic [3:0]             n_state;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic                   r_crypt;
    logic                   n_crypt;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic                   out_free;
    logic                   cnt_last;

    assign out_free = !r_out_valid || !i_stall;
    assign cnt_last = (r_cnt == COUNT_WIDTH'(1));
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;

    // sequence the datapath
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_crypt = r_crypt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_mode)
                        rc4_pkg::MODE_KEY: begin
                            o_cmd.key_wr = 1'b1;
                            if (i_key_last) begin
                                o_cmd.sched_init = 1'b1;
                                n_state          = S_K_RD_I;
                            end
                        end
                        rc4_pkg::MODE_CRYPT: begin
                            o_cmd.rd_sel     = rc4_pkg::RD_I1;
                            o_cmd.i_inc      = 1'b1;
                            o_cmd.latch_data = 1'b1;
                            n_crypt          = 1'b1;
                            n_state          = S_F_RD_J;
                        end
                        rc4_pkg::MODE_SKIP: begin
                            if (i_step_count != '0) begin
                                o_cmd.rd_sel = rc4_pkg::RD_I1;
                                o_cmd.i_inc  = 1'b1;
                                n_crypt      = 1'b0;
                                n_cnt        = i_step_count;
                                n_state      = S_F_RD_J;
                            end
                        end
                        rc4_pkg::MODE_BACK: begin
                            if (i_step_count != '0) begin
                                o_cmd.rd_sel = rc4_pkg::RD_I;
                                n_cnt        = i_step_count;
                                n_state      = S_B_RD_J;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            // forward generator step
            S_F_RD_I: begin
                o_cmd.rd_sel = rc4_pkg::RD_I1;
                o_cmd.i_inc  = 1'b1;
                n_state      = S_F_RD_J;
            end
            S_F_RD_J: begin
                o_cmd.rd_sel = rc4_pkg::RD_JA;
                o_cmd.j_add  = 1'b1;
                o_cmd.cap_a  = 1'b1;
                n_state      = S_F_SWAP;
            end
            S_F_SWAP: begin
                o_cmd.wr_sel = rc4_pkg::WR_I_RDATA;
                o_cmd.cap_b  = 1'b1;
                o_cmd.rd_sel = rc4_pkg::RD_T;
                n_state      = S_F_DONE;
            end
            S_F_DONE: begin
                o_cmd.wr_sel = rc4_pkg::WR_J_A;
                if (r_crypt) begin
                    if (out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.cap_res = 1'b1;
                        n_state       = S_OUT_WAIT;
                    end
                end else if (cnt_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt - COUNT_WIDTH'(1);
                    n_state = S_F_RD_I;
                end
            end
            // hold the keystream byte until the output frees up
            S_OUT_WAIT: begin
                if (out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_from_res = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            // key schedule round
            S_K_RD_I: begin
                o_cmd.rd_sel = rc4_pkg::RD_I;
                o_cmd.key_rd = 1'b1;
                n_state      = S_K_RD_J;
            end
            S_K_RD_J: begin
                o_cmd.rd_sel  = rc4_pkg::RD_JA;
                o_cmd.j_add   = 1'b1;
                o_cmd.use_key = 1'b1;
                o_cmd.cap_a   = 1'b1;
                n_state       = S_K_SWAP;
            end
            S_K_SWAP: begin
                o_cmd.wr_sel = rc4_pkg::WR_I_RDATA;
                n_state      = S_K_DONE;
            end
            S_K_DONE: begin
                o_cmd.wr_sel   = rc4_pkg::WR_J_A;
                o_cmd.i_inc    = 1'b1;
                o_cmd.key_step = 1'b1;
                if (i_status.i_max) begin
                    o_cmd.sched_done = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_K_RD_I;
                end
            end
            // backward generator step
            S_B_RD_I: begin
                o_cmd.rd_sel = rc4_pkg::RD_I;
                n_state      = S_B_RD_J;
            end
            S_B_RD_J: begin
                o_cmd.rd_sel = rc4_pkg::RD_J;
                o_cmd.cap_a  = 1'b1;
                n_state      = S_B_SWAP;
            end
            S_B_SWAP: begin
                o_cmd.cap_b  = 1'b1;
                o_cmd.wr_sel = rc4_pkg::WR_J_A;
                n_state      = S_B_DONE;
            end
            S_B_DONE: begin
                o_cmd.wr_sel = rc4_pkg::WR_I_B;
                o_cmd.j_sub  = 1'b1;
                o_cmd.i_dec  = 1'b1;
                if (cnt_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt - COUNT_WIDTH'(1);
                    n_state = S_B_RD_I;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result beat valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_crypt     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_crypt     <= n_crypt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
